// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the SIC executor.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert that a signal is never high while another condition holds.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- src/sic_pkg.sv -----
// Package of the SIC executor: widths, opcodes, payload structs and shared types.
// Depends on nothing.
package sic_pkg;

  localparam int unsigned MemBytes = 32768;
  localparam int unsigned AddrW    = $clog2(MemBytes);
  localparam int unsigned WordW    = 24;
  localparam logic [WordW-1:0] WordOnes = '1;

  // Input modes.
  localparam logic [1:0] ModeLoad    = 2'd0;
  localparam logic [1:0] ModeExec    = 2'd1;
  localparam logic [1:0] ModeRestart = 2'd2;

  // Opcodes.
  localparam logic [7:0] OpLda  = 8'd0;
  localparam logic [7:0] OpLdx  = 8'd4;
  localparam logic [7:0] OpSta  = 8'd12;
  localparam logic [7:0] OpStx  = 8'd16;
  localparam logic [7:0] OpAdd  = 8'd24;
  localparam logic [7:0] OpSub  = 8'd28;
  localparam logic [7:0] OpMul  = 8'd32;
  localparam logic [7:0] OpDiv  = 8'd36;
  localparam logic [7:0] OpComp = 8'd40;
  localparam logic [7:0] OpJeq  = 8'd48;
  localparam logic [7:0] OpJgt  = 8'd52;
  localparam logic [7:0] OpJlt  = 8'd56;
  localparam logic [7:0] OpJsub = 8'd72;
  localparam logic [7:0] OpRsub = 8'd76;

  // Condition codes.
  localparam logic [1:0] CcEq = 2'd0;
  localparam logic [1:0] CcGt = 2'd1;
  localparam logic [1:0] CcLt = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [0:0] RegStart = 1'd0;
  localparam logic [0:0] RegEnd   = 1'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] load_address;
    logic [7:0]  load_byte;
  } in_word_t;

  typedef struct packed {
    logic [23:0] accumulator;
    logic [23:0] index_value;
    logic [14:0] link_value;
    logic [14:0] program_counter;
    logic [1:0]  condition_code;
    logic        halted;
    logic        divide_error;
  } out_word_t;

  // Shared arithmetic unit operations.
  typedef enum logic [1:0] {
    AluAdd,
    AluSub,
    AluMul,
    AluDiv
  } alu_op_e;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [23:0] a;
    logic [23:0] b;
  } alu_req_t;

  // Response from the arithmetic unit.
  typedef struct packed {
    logic        done;
    logic [23:0] result;
  } alu_rsp_t;

endpackage

// ----- src/sic_mem.sv -----
// Byte memory of the SIC executor: one port, registered read data.
// Depends on sic_pkg.
module sic_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [sic_pkg::AddrW-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic [7:0]                rdata_o
);
  import sic_pkg::*;

  logic [7:0] mem_q [MemBytes];

  // Single port: write or read one byte per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- src/sic_alu.sv -----
// Shared arithmetic unit: add and subtract in a single step, shift-add multiply and
// restoring divide one bit per cycle. Depends on sic_pkg.
module sic_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sic_pkg::alu_req_t req_i,
  output sic_pkg::alu_rsp_t rsp_o
);
  import sic_pkg::*;

  logic          busy_q, busy_d;
  alu_op_e       op_q, op_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [23:0]   a_q, a_d;     // multiplicand, or dividend shifting into quotient
  logic [23:0]   b_q, b_d;     // multiplier, or divisor
  logic [23:0]   acc_q, acc_d; // product, or partial remainder
  logic          done_q, done_d;
  logic [24:0]   trial;

  assign trial = {acc_q, a_q[23]} - {1'b0, b_q};

  // Sequencer of the shared unit.
  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      op_d = req_i.op;
      a_d  = req_i.a;
      b_d  = req_i.b;
      cnt_d = 5'd0;
      case (req_i.op)
        AluAdd: begin
          acc_d = req_i.a + req_i.b;
          done_d = 1'b1;
        end
        AluSub: begin
          acc_d = req_i.a - req_i.b;
          done_d = 1'b1;
        end
        default: begin
          acc_d = '0;
          busy_d = 1'b1;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        AluMul: begin
          if (b_q[0]) begin
            acc_d = acc_q + a_q;
          end
          a_d = {a_q[22:0], 1'b0};
          b_d = {1'b0, b_q[23:1]};
        end
        default: begin
          if (!trial[24]) begin
            acc_d = trial[23:0];
          end else begin
            acc_d = {acc_q[22:0], a_q[23]};
          end
          a_d = {a_q[22:0], ~trial[24]};
        end
      endcase
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= AluAdd;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == AluDiv) ? a_q : acc_q;

endmodule

// ----- src/sic_instruction_executor_unit.sv -----
// SIC executor top level: configuration port, sequencer, byte memory and the
// shared arithmetic unit. Depends on sic_pkg, sic_mem, sic_alu, assert_macros.svh.
//
// Each input word loads one memory byte, restarts at the start address, or
// executes one 3-byte instruction; one result word follows every input word.
// A load, a restart, an unused mode or an execute while halted shows its
// result in the cycle after it is taken. An instruction fetches its 3 bytes
// one at a time through the single-port memory, decodes, and then: a jump or
// an unknown opcode finishes; a store writes 3 bytes; LDA, LDX, COMP, ADD,
// SUB, MUL and DIV read a 3-byte operand, and ADD, SUB, MUL and a DIV by a
// nonzero divisor then wait on the shared shift-add/restoring-divide unit.
// The block takes no new word until the result of the present one has been
// taken and it is back in its idle state. Memory has no reset: a byte must be
// loaded before it is read.
module sic_instruction_executor_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sic_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sic_pkg::out_word_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sic_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    StIdle,
    StFetch,
    StFetchWait,
    StDecode,
    StOpRead,
    StOpWait,
    StOpWrite,
    StAluWait,
    StFinish,
    StOut
  } state_e;

  // Configuration registers.
  logic [AddrW-1:0] start_q, end_q;
  logic             cfg_we;
  logic [0:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_we && paddr[1:0] == 2'd0) begin
      case (cfg_idx)
        RegStart: start_q <= pwdata[AddrW-1:0];
        RegEnd:   end_q   <= pwdata[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      RegStart: prdata[AddrW-1:0] = start_q;
      RegEnd:   prdata[AddrW-1:0] = end_q;
      default: ;
    endcase
  end

  // Architectural and sequencer state.
  state_e           state_q;
  logic [23:0]      acc_q, x_q;
  logic [AddrW-1:0] l_q, pc_q;
  logic [1:0]       cc_q;
  logic             halt_q, derr_q;
  logic [1:0]       cnt_q;
  logic [7:0]       op_q, lo_q, hi_q;
  logic [23:0]      val_q;
  logic [AddrW-1:0] ea_q;
  logic             out_valid_q;

  // Memory port.
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;

  sic_mem u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  sic_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  logic             accept;
  logic [AddrW-1:0] direct, indexed, pc_next3;
  logic             is_word_op, is_store;
  logic [23:0]      store_val;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign direct   = AddrW'({hi_q[6:0], lo_q});
  assign indexed  = hi_q[7] ? direct + x_q[AddrW-1:0] : direct;
  assign pc_next3 = pc_q + AddrW'(3);
  assign is_word_op = (op_q == OpLda) || (op_q == OpLdx) || (op_q == OpAdd) ||
                      (op_q == OpSub) || (op_q == OpMul) || (op_q == OpDiv) ||
                      (op_q == OpComp);
  assign is_store  = (op_q == OpSta) || (op_q == OpStx);
  assign store_val = (op_q == OpSta) ? acc_q : x_q;

  // Memory address and write selection by state.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = pc_q + AddrW'(cnt_q);
    mem_wdata = in_data_i.load_byte;
    case (state_q)
      StIdle: begin
        mem_addr = in_data_i.load_address[AddrW-1:0];
        mem_we   = accept && in_data_i.mode == ModeLoad;
      end
      StOpRead: mem_addr = ea_q + AddrW'(cnt_q);
      StOpWrite: begin
        mem_addr  = ea_q + AddrW'(cnt_q);
        mem_we    = 1'b1;
        mem_wdata = store_val[8*cnt_q +: 8];
      end
      default: ;
    endcase
  end

  // Arithmetic request, issued as the operand word completes.
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = AluAdd;
    alu_req.a     = acc_q;
    alu_req.b     = {mem_rdata, val_q[23:8]};
    if (state_q == StOpWait && cnt_q == 2'd2) begin
      case (op_q)
        OpAdd: begin alu_req.start = 1'b1; alu_req.op = AluAdd; end
        OpSub: begin alu_req.start = 1'b1; alu_req.op = AluSub; end
        OpMul: begin alu_req.start = 1'b1; alu_req.op = AluMul; end
        OpDiv: begin
          alu_req.start = alu_req.b != '0;
          alu_req.op = AluDiv;
        end
        default: ;
      endcase
    end
  end

  // Sequencer with registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      acc_q       <= '0;
      x_q         <= '0;
      l_q         <= '0;
      pc_q        <= '0;
      cc_q        <= CcEq;
      halt_q      <= 1'b0;
      derr_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) begin
            derr_q <= 1'b0;
            cnt_q  <= '0;
            if (in_data_i.mode == ModeExec && !halt_q) begin
              state_q <= StFetch;
            end else begin
              if (in_data_i.mode == ModeRestart) begin
                acc_q  <= '0;
                x_q    <= '0;
                l_q    <= '0;
                cc_q   <= CcEq;
                halt_q <= 1'b0;
                pc_q   <= start_q;
              end
              out_valid_q <= 1'b1;
              state_q     <= StOut;
            end
          end
        end
        StFetch: state_q <= StFetchWait;
        StFetchWait: begin
          case (cnt_q)
            2'd0: op_q <= mem_rdata;
            2'd1: lo_q <= mem_rdata;
            default: hi_q <= mem_rdata;
          endcase
          if (cnt_q == 2'd2) begin
            cnt_q   <= '0;
            state_q <= StDecode;
          end else begin
            cnt_q   <= cnt_q + 2'd1;
            state_q <= StFetch;
          end
        end
        StDecode: begin
          ea_q <= (op_q == OpComp) ? direct : indexed;
          if (is_word_op) begin
            state_q <= StOpRead;
          end else if (is_store) begin
            state_q <= StOpWrite;
          end else begin
            state_q <= StFinish;
          end
        end
        StOpRead: state_q <= StOpWait;
        StOpWait: begin
          val_q <= {mem_rdata, val_q[23:8]};
          if (cnt_q == 2'd2) begin
            cnt_q <= '0;
            case (op_q)
              OpLda: begin acc_q <= alu_req.b; state_q <= StFinish; end
              OpLdx: begin x_q <= alu_req.b; state_q <= StFinish; end
              OpComp: begin
                if (acc_q == alu_req.b) cc_q <= CcEq;
                else if (acc_q > alu_req.b) cc_q <= CcGt;
                else cc_q <= CcLt;
                state_q <= StFinish;
              end
              OpDiv: begin
                if (alu_req.b == '0) begin
                  acc_q   <= WordOnes;
                  derr_q  <= 1'b1;
                  state_q <= StFinish;
                end else begin
                  state_q <= StAluWait;
                end
              end
              default: state_q <= StAluWait;
            endcase
          end else begin
            cnt_q   <= cnt_q + 2'd1;
            state_q <= StOpRead;
          end
        end
        StOpWrite: begin
          if (cnt_q == 2'd2) begin
            cnt_q   <= '0;
            state_q <= StFinish;
          end else begin
            cnt_q <= cnt_q + 2'd1;
          end
        end
        StAluWait: begin
          if (alu_rsp.done) begin
            acc_q   <= alu_rsp.result;
            state_q <= StFinish;
          end
        end
        StFinish: begin
          logic [AddrW-1:0] nxt;
          nxt = pc_next3;
          case (op_q)
            OpJeq: if (cc_q == CcEq) nxt = direct;
            OpJgt: if (cc_q == CcGt) nxt = direct;
            OpJlt: if (cc_q == CcLt) nxt = direct;
            OpJsub: begin
              l_q <= pc_q;
              nxt = direct;
            end
            OpRsub: nxt = l_q + AddrW'(3);
            default: ;
          endcase
          pc_q <= nxt;
          if (nxt == end_q) halt_q <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= StOut;
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Result word, read straight from the architectural registers.
  assign out_valid_o                = out_valid_q;
  assign out_data_o.accumulator     = acc_q;
  assign out_data_o.index_value     = x_q;
  assign out_data_o.link_value      = l_q;
  assign out_data_o.program_counter = pc_q;
  assign out_data_o.condition_code  = cc_q;
  assign out_data_o.halted          = halt_q;
  assign out_data_o.divide_error    = derr_q;

  `ASSERT_IMPL(a_valid_in_out, clk_i, rst_ni, out_valid_o |-> state_q == StOut, "result valid outside output state")
  `ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, out_valid_o && !in_stall_o, "input taken while a result waits")
  `ASSERT_IMPL(a_cc_code, clk_i, rst_ni, cc_q != 2'd3, "condition code out of range")
  `ASSERT_IMPL(a_halt_exec, clk_i, rst_ni, (accept && halt_q && in_data_i.mode == ModeExec) |=> state_q == StOut, "halted execute did work")

endmodule
